// ----- src/spq_pkg.sv -----
// Shared constants, codes and types for the strict priority class queue.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_CLASSES = 4;

    localparam int CLASS_W   = 2;
    localparam int AGE_W     = 8;
    localparam int TAG_W     = 16;
    localparam int ENTRY_W   = AGE_W + TAG_W;
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int CIDX_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int DATA_W    = 32;

    typedef enum logic {
        CMD_ARRIVE = 1'b0,
        CMD_SERVE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_DROPPED  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        logic arrive;
        logic serve;
        logic load_serve;
    } spq_ctl_t;

endpackage

// ----- src/strict_priority_four_class_queue.sv -----
// Top level of the strict priority four class queue.
//
//  port group  dir  tdata (lsb up)                       tuser
//  s_*         in   class[1:0] age[9:2] tag[25:10]       cmd[0]
//  m_*         out  class[1:0] age[9:2] tag[25:10]       status[1:0]
//
//  An arrive word's result is in the output register the next cycle.
//  A serve word does the pick, pointer update and registered read of the entry
//  memory, then loads the output register in the read state.
//  Reset is synchronous on aresetn low; queues come up empty, no clearing pass.
//  A new word is taken while the output word is being accepted; a stalled
//  output word holds s_tready low.
module strict_priority_four_class_queue import spq_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // class[1:0], age[9:2], tag[25:10], upper bits unused
    input  logic [0:0]        s_tuser,   // cmd[0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // served_class[1:0], served_age[9:2], served_tag[25:10]
    output logic [1:0]        m_tuser    // status[1:0]
);

    spq_ctl_t           ctl;
    cmd_t               cmd;
    status_t            out_status;
    logic [CLASS_W-1:0] out_class;
    logic [AGE_W-1:0]   out_age;
    logic [TAG_W-1:0]   out_tag;

    assign cmd = cmd_t'(s_tuser[0]);

    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    spq_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .in_class   (s_tdata[CLASS_W-1:0]),
        .in_age     (s_tdata[CLASS_W+AGE_W-1:CLASS_W]),
        .in_tag     (s_tdata[CLASS_W+AGE_W+TAG_W-1:CLASS_W+AGE_W]),
        .out_status (out_status),
        .out_class  (out_class),
        .out_age    (out_age),
        .out_tag    (out_tag)
    );

    assign m_tdata = {{(DATA_W - CLASS_W - AGE_W - TAG_W){1'b0}}, out_tag, out_age, out_class};
    assign m_tuser = out_status;

endmodule

// ----- src/spq_ctrl.sv -----
// Controller: input handshake, serve read sequencing and output word valid.
module spq_ctrl import spq_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  cmd_t     cmd,
    output logic     m_tvalid,
    input  logic     m_tready,
    output spq_ctl_t ctl
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ctl            = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (cmd == CMD_ARRIVE) begin
                        ctl.arrive     = 1'b1;
                        out_valid_next = 1'b1;
                    end else begin
                        ctl.serve  = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                ctl.load_serve = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_arrive_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == CMD_ARRIVE) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("arrive did not produce a word");

    a_serve_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == CMD_SERVE) |=> (state_reg == S_READ && !out_valid_reg))
        else $error("serve did not enter read with a free output register");

    a_read_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("read cycle did not load the output register");

endmodule

// ----- src/spq_dp.sv -----
// Datapath: entry memory, per-class pointers and counts, priority pick, result register.
module spq_dp import spq_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  spq_ctl_t           ctl,
    input  logic [CLASS_W-1:0] in_class,
    input  logic [AGE_W-1:0]   in_age,
    input  logic [TAG_W-1:0]   in_tag,
    output status_t            out_status,
    output logic [CLASS_W-1:0] out_class,
    output logic [AGE_W-1:0]   out_age,
    output logic [TAG_W-1:0]   out_tag
);

    logic [ENTRY_W-1:0] mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [PTR_W-1:0] head_reg  [NUM_CLASSES];
    logic [PTR_W-1:0] head_next [NUM_CLASSES];
    logic [PTR_W-1:0] tail_reg  [NUM_CLASSES];
    logic [PTR_W-1:0] tail_next [NUM_CLASSES];
    logic [CNT_W-1:0] count_reg  [NUM_CLASSES];
    logic [CNT_W-1:0] count_next [NUM_CLASSES];

    logic              pick_found_reg;
    logic [CIDX_W-1:0] pick_cls_reg;

    status_t            status_reg;
    logic [CLASS_W-1:0] class_reg;
    logic [AGE_W-1:0]   age_reg;
    logic [TAG_W-1:0]   tag_reg;

    logic              class_ok;
    logic [CIDX_W-1:0] arr_idx;
    logic              arr_full;
    logic              do_write;
    logic [ADDR_W-1:0] wr_addr;
    logic              pick_found;
    logic [CIDX_W-1:0] pick_cls;
    logic [ADDR_W-1:0] rd_addr;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign class_ok = (32'(in_class) < NUM_CLASSES);
    assign arr_idx  = CIDX_W'(in_class);
    assign arr_full = (count_reg[arr_idx] == CNT_W'(QUEUE_DEPTH));
    assign do_write = ctl.arrive && class_ok && !arr_full;
    assign wr_addr  = ADDR_W'(arr_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_reg[arr_idx]);

    // most urgent non-empty class
    always_comb begin
        pick_found = 1'b0;
        pick_cls   = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (count_reg[c] != '0) begin
                pick_found = 1'b1;
                pick_cls   = CIDX_W'(c);
            end
        end
    end

    assign rd_addr = ADDR_W'(pick_cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_reg[pick_cls]);

    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            head_next[c]  = head_reg[c];
            tail_next[c]  = tail_reg[c];
            count_next[c] = count_reg[c];
        end
        if (do_write) begin
            tail_next[arr_idx]  = next_slot(tail_reg[arr_idx]);
            count_next[arr_idx] = count_reg[arr_idx] + 1'b1;
        end
        if (ctl.serve && pick_found) begin
            head_next[pick_cls]  = next_slot(head_reg[pick_cls]);
            count_next[pick_cls] = count_reg[pick_cls] - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_reg[c]  <= '0;
                tail_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
        end else begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_reg[c]  <= head_next[c];
                tail_reg[c]  <= tail_next[c];
                count_reg[c] <= count_next[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[wr_addr] <= {in_age, in_tag};
        end
        if (ctl.serve) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.serve) begin
            pick_found_reg <= pick_found;
            pick_cls_reg   <= pick_cls;
        end
        if (ctl.arrive) begin
            status_reg <= do_write ? ST_ENQUEUED : ST_DROPPED;
            class_reg  <= '0;
            age_reg    <= '0;
            tag_reg    <= '0;
        end else if (ctl.load_serve) begin
            if (pick_found_reg) begin
                status_reg <= ST_SERVED;
                class_reg  <= CLASS_W'(pick_cls_reg);
                age_reg    <= rd_data_reg[ENTRY_W-1:TAG_W];
                tag_reg    <= rd_data_reg[TAG_W-1:0];
            end else begin
                status_reg <= ST_EMPTY;
                class_reg  <= '0;
                age_reg    <= '0;
                tag_reg    <= '0;
            end
        end
    end

    assign out_status = status_reg;
    assign out_class  = class_reg;
    assign out_age    = age_reg;
    assign out_tag    = tag_reg;

endmodule
